>>> sv/sccb_register_read_master_assert.svh
// Assertion macros for the SCCB register read master.
// Used inside module bodies that declare clk and arst_n.
`ifndef SCCB_REGISTER_READ_MASTER_ASSERT_SVH
`define SCCB_REGISTER_READ_MASTER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SRRM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define SRRM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/srrm_pkg.sv
// Shared types and constants of the SCCB register read master.
// No dependencies.
`timescale 1ns / 1ps

package srrm_pkg;

	localparam logic [7:0] QUARTER_BIT_CLOCKS_RESET = 8'd60;
	localparam logic [3:0] IDLE_BITS_RESET          = 4'd4;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_QUARTER_BIT_CLOCKS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IDLE_BITS          = 2'd1;

	typedef enum logic [2:0] {
		TOP_IDLE    = 3'b001,
		TOP_RUN     = 3'b010,
		TOP_PRESENT = 3'b100
	} top_state_t;

	typedef enum logic [3:0] {
		SEQ_WRITE      = 4'b0001,
		SEQ_WRITE_IDLE = 4'b0010,
		SEQ_READ       = 4'b0100,
		SEQ_READ_IDLE  = 4'b1000
	} seq_state_t;

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_WRITE = 4'b0010,
		PH_READ  = 4'b0100,
		PH_STOP  = 4'b1000
	} phase_state_t;

	// First: load (write) or receive (read). Mid: shift (write) or wait (read).
	typedef enum logic [2:0] {
		BYTE_FIRST = 3'b001,
		BYTE_MID   = 3'b010,
		BYTE_ACK   = 3'b100
	} byte_state_t;

endpackage

>>> sv/sccb_register_read_master.sv
// SCCB register read master: one input transaction per system clock tick,
// sustained while the output is not stalled. An accepted transaction goes
// from the input register through the single step stage into the result
// register.
// Reset (arst_n low): sequencer idle, counters and bytes cleared, timing
// registers back to QUARTER_BIT_CLOCKS_RESET and 4 idle bits.
`timescale 1ns / 1ps

module sccb_register_read_master (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [srrm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [7:0]                         cfg_data,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               request_valid,
	input  logic [7:0]                         dev_id,
	input  logic [7:0]                         reg_addr,
	input  logic                               result_taken,
	input  logic                               sda_in,
	// output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               scl,
	output logic                               sda_out,
	output logic                               sda_drive_enable,
	output logic                               request_ready,
	output logic                               result_valid,
	output logic [7:0]                         read_byte
);

	import srrm_pkg::*;

	// configuration
	logic [7:0] qbc_q;
	logic [3:0] idle_bits_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qbc_q       <= QUARTER_BIT_CLOCKS_RESET;
			idle_bits_q <= IDLE_BITS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_QUARTER_BIT_CLOCKS: qbc_q <= cfg_data;
				REG_IDLE_BITS:          idle_bits_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// input register
	logic       valid_s1;
	logic       req_s1;
	logic [7:0] id_s1;
	logic [7:0] addr_s1;
	logic       taken_s1;
	logic       sda_s1;
	logic       adv;
	logic       in_acc;

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1   <= request_valid;
			id_s1    <= dev_id;
			addr_s1  <= reg_addr;
			taken_s1 <= result_taken;
			sda_s1   <= sda_in;
		end
	end

	// sequencer state
	top_state_t   top_q,   top_d;
	seq_state_t   seq_q,   seq_d;
	phase_state_t phase_q, phase_d;
	byte_state_t  byte_q,  byte_d;
	logic [7:0]   held_id_q,   held_id_d;
	logic [7:0]   held_addr_q, held_addr_d;
	logic [7:0]   result_q,    result_d;
	logic [15:0]  idle_cnt_q,  idle_cnt_d;
	logic [8:0]   hbc_q,       hbc_d;
	logic         clk_lvl_q,   clk_lvl_d;
	logic         pidx_q,      pidx_d;
	logic [7:0]   qcnt_q,      qcnt_d;
	logic [1:0]   qi_q,        qi_d;
	logic [7:0]   shift_q,     shift_d;
	logic [2:0]   bitcnt_q,    bitcnt_d;

	// timing values
	logic [8:0]  q9;
	logic [7:0]  q_m1;
	logic [8:0]  half_mid;
	logic [8:0]  half_last;
	logic [12:0] idle_prod;
	logic [15:0] idle_target;

	assign q9          = (qbc_q == 8'd0) ? 9'd256 : {1'b0, qbc_q};
	assign q_m1        = qbc_q - 8'd1;
	assign half_mid    = q9 - 9'd1;
	assign half_last   = 9'({q9, 1'b0} - 10'd1);
	assign idle_prod   = 13'(idle_bits_q) * 13'(q9);
	assign idle_target = 16'({idle_prod, 2'b00}) - 16'd1;

	// step outputs
	logic       o_scl, o_sda, o_en, o_rdy, o_vld;
	logic [7:0] o_rb;

	logic        rd, mid, change, sample, idle_done;
	logic        q_wrap, q_done;
	logic [7:0]  wr_data, eff_shift;
	logic [2:0]  eff_bc;
	byte_state_t eff_bs;
	logic        wr_done;

	assign q_wrap = (qcnt_q == q_m1);
	assign q_done = q_wrap && (qi_q == 2'd3);

	always_comb begin
		top_d       = top_q;
		seq_d       = seq_q;
		phase_d     = phase_q;
		byte_d      = byte_q;
		held_id_d   = held_id_q;
		held_addr_d = held_addr_q;
		result_d    = result_q;
		idle_cnt_d  = idle_cnt_q;
		hbc_d       = hbc_q;
		clk_lvl_d   = clk_lvl_q;
		pidx_d      = pidx_q;
		qcnt_d      = qcnt_q;
		qi_d        = qi_q;
		shift_d     = shift_q;
		bitcnt_d    = bitcnt_q;

		o_scl = 1'b1;
		o_sda = 1'b1;
		o_en  = 1'b1;
		o_rdy = 1'b0;
		o_vld = 1'b0;
		o_rb  = result_q;

		rd        = (seq_q == SEQ_READ);
		mid       = (hbc_q == half_mid);
		change    = !clk_lvl_q && mid;
		sample    = clk_lvl_q && mid;
		idle_done = (idle_cnt_q == idle_target);
		wr_data   = 8'd0;
		eff_shift = shift_q;
		eff_bc    = bitcnt_q;
		eff_bs    = byte_q;
		wr_done   = 1'b0;

		case (top_q)
			TOP_IDLE: begin
				o_rdy = 1'b1;
				if (req_s1) begin
					held_id_d   = id_s1;
					held_addr_d = addr_s1;
					top_d       = TOP_RUN;
				end
			end
			TOP_RUN: begin
				idle_cnt_d = idle_cnt_q + 16'd1;
				case (seq_q)
					SEQ_WRITE, SEQ_READ: begin
						o_scl = clk_lvl_q;
						if (hbc_q == half_last) begin
							hbc_d     = 9'd0;
							clk_lvl_d = !clk_lvl_q;
						end else begin
							hbc_d = hbc_q + 9'd1;
						end

						// quarter timer, used by start and stop conditions
						if (phase_q == PH_START || phase_q == PH_STOP) begin
							if (q_wrap) begin
								qcnt_d = 8'd0;
								qi_d   = qi_q + 2'd1;
							end else begin
								qcnt_d = qcnt_q + 8'd1;
							end
						end

						case (phase_q)
							PH_START: begin
								o_scl = (qi_q != 2'd3);
								o_sda = (qi_q < 2'd2);
								if (q_done) begin
									hbc_d     = q9;
									clk_lvl_d = 1'b0;
									pidx_d    = 1'b0;
									phase_d   = PH_WRITE;
								end
							end
							PH_WRITE: begin
								if (rd)
									wr_data = held_id_q | 8'h01;
								else
									wr_data = pidx_q ? held_addr_q : (held_id_q & 8'hFE);
								if (byte_q == BYTE_FIRST) begin
									eff_shift = wr_data;
									eff_bc    = 3'd0;
									eff_bs    = BYTE_MID;
								end
								shift_d  = eff_shift;
								bitcnt_d = eff_bc;
								byte_d   = eff_bs;
								case (eff_bs)
									BYTE_MID: begin
										o_sda = eff_shift[7];
										if (change) begin
											shift_d = {eff_shift[6:0], 1'b0};
											if (eff_bc == 3'd7)
												byte_d = BYTE_ACK;
											else
												bitcnt_d = eff_bc + 3'd1;
										end
									end
									BYTE_ACK: begin
										// acknowledge slot driven low
										o_sda = 1'b0;
										if (change) begin
											byte_d   = BYTE_FIRST;
											bitcnt_d = 3'd0;
											wr_done  = 1'b1;
										end
									end
									default: ;
								endcase
								if (wr_done) begin
									if (rd)
										phase_d = PH_READ;
									else if (pidx_q)
										phase_d = PH_STOP;
									else
										pidx_d = 1'b1;
								end
							end
							PH_READ: begin
								if (rd) begin
									o_sda = 1'b0;
									o_en  = 1'b0;
									case (byte_q)
										BYTE_FIRST: begin
											if (sample) begin
												shift_d = {shift_q[6:0], sda_s1};
												if (bitcnt_q == 3'd7)
													byte_d = BYTE_MID;
												else
													bitcnt_d = bitcnt_q + 3'd1;
											end
										end
										BYTE_MID: begin
											if (change)
												byte_d = BYTE_ACK;
										end
										BYTE_ACK: begin
											// no-acknowledge
											o_sda = 1'b1;
											o_en  = 1'b1;
											if (change) begin
												byte_d   = BYTE_FIRST;
												bitcnt_d = 3'd0;
												phase_d  = PH_STOP;
											end
										end
										default: ;
									endcase
								end
							end
							default: begin
								o_scl = (qi_q != 2'd0);
								o_sda = (qi_q >= 2'd2);
								if (q_done) begin
									phase_d    = PH_START;
									seq_d      = rd ? SEQ_READ_IDLE : SEQ_WRITE_IDLE;
									idle_cnt_d = 16'd0;
								end
							end
						endcase
					end
					SEQ_WRITE_IDLE: begin
						if (idle_done)
							seq_d = SEQ_READ;
					end
					default: begin
						if (idle_done) begin
							result_d = shift_q;
							top_d    = TOP_PRESENT;
							seq_d    = SEQ_WRITE;
						end
					end
				endcase
			end
			TOP_PRESENT: begin
				o_vld = 1'b1;
				if (taken_s1)
					top_d = TOP_IDLE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= TOP_IDLE;
			seq_q       <= SEQ_WRITE;
			phase_q     <= PH_START;
			byte_q      <= BYTE_FIRST;
			held_id_q   <= 8'd0;
			held_addr_q <= 8'd0;
			result_q    <= 8'd0;
			idle_cnt_q  <= 16'd0;
			hbc_q       <= 9'd0;
			clk_lvl_q   <= 1'b0;
			pidx_q      <= 1'b0;
			qcnt_q      <= 8'd0;
			qi_q        <= 2'd0;
			shift_q     <= 8'd0;
			bitcnt_q    <= 3'd0;
		end else if (adv) begin
			top_q       <= top_d;
			seq_q       <= seq_d;
			phase_q     <= phase_d;
			byte_q      <= byte_d;
			held_id_q   <= held_id_d;
			held_addr_q <= held_addr_d;
			result_q    <= result_d;
			idle_cnt_q  <= idle_cnt_d;
			hbc_q       <= hbc_d;
			clk_lvl_q   <= clk_lvl_d;
			pidx_q      <= pidx_d;
			qcnt_q      <= qcnt_d;
			qi_q        <= qi_d;
			shift_q     <= shift_d;
			bitcnt_q    <= bitcnt_d;
		end
	end

	// result register
	logic       out_valid_q;
	logic       scl_q, sda_q, en_q, rdy_q, vld_q;
	logic [7:0] rb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			scl_q <= o_scl;
			sda_q <= o_sda;
			en_q  <= o_en;
			rdy_q <= o_rdy;
			vld_q <= o_vld;
			rb_q  <= o_rb;
		end
	end

	assign out_valid        = out_valid_q;
	assign scl              = scl_q;
	assign sda_out          = sda_q;
	assign sda_drive_enable = en_q;
	assign request_ready    = rdy_q;
	assign result_valid     = vld_q;
	assign read_byte        = rb_q;

`include "sccb_register_read_master_assert.svh"

	`SRRM_ASSERT_IMPL(a_ready_excl_valid, out_valid_q && vld_q, !rdy_q,
		"request_ready and result_valid both set")
	`SRRM_ASSERT_IMPL(a_released_low, out_valid_q && !en_q, !sda_q,
		"sda_out high while pin released")
	`SRRM_ASSERT_IMPL(a_present_rewound, top_q == TOP_PRESENT,
		seq_q == SEQ_WRITE && phase_q == PH_START,
		"byte presented before sequencer rewound")
	`SRRM_ASSERT_IMPL(a_start_byte_first, phase_q == PH_START,
		byte_q == BYTE_FIRST && bitcnt_q == 3'd0,
		"start condition with byte transfer pending")
	`SRRM_ASSERT_NEXT(a_stall_holds_state, valid_s1 && !adv,
		$stable(top_q) && $stable(hbc_q) && $stable(shift_q),
		"sequencer moved while output stalled")

endmodule

>>> tb/sccb_register_read_master_test.sv
// Self-checking testbench for the SCCB register read master.
// Drives one bus tick per input transaction and compares every output tick with
// a directed row or a sequencer predictor; depends on srrm_pkg and the RTL.
`timescale 1ns / 1ps

module sccb_register_read_master_test;

	import srrm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		logic       request_valid;
		logic [7:0] dev_id;
		logic [7:0] reg_addr;
		logic       result_taken;
		logic       sda_in;
	} tick_in_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive_enable;
		logic       request_ready;
		logic       result_valid;
		logic [7:0] read_byte;
	} pins_t;

	typedef struct packed {
		tick_in_t stim;
		logic     typed;
		pins_t    want;
	} directed_row_t;

	localparam pins_t BUS_IDLE  = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00};
	localparam pins_t BUS_START = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00};
	localparam pins_t NO_PINS   = '0;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [7:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic request_valid;
	logic [7:0] dev_id;
	logic [7:0] reg_addr;
	logic result_taken;
	logic sda_in;
	logic out_valid;
	logic out_stall;
	logic scl;
	logic sda_out;
	logic sda_drive_enable;
	logic request_ready;
	logic result_valid;
	logic [7:0] read_byte;

	sccb_register_read_master i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.request_valid    (request_valid),
		.dev_id           (dev_id),
		.reg_addr         (reg_addr),
		.result_taken     (result_taken),
		.sda_in           (sda_in),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.scl              (scl),
		.sda_out          (sda_out),
		.sda_drive_enable (sda_drive_enable),
		.request_ready    (request_ready),
		.result_valid     (result_valid),
		.read_byte        (read_byte)
	);

	// Predictor copy of the timing registers and sequencer state.
	logic [7:0]   quarter_clocks;
	logic [3:0]   idle_bit_count;
	top_state_t   p_top;
	logic [7:0]   p_id;
	logic [7:0]   p_addr;
	logic [7:0]   p_result;
	seq_state_t   p_seq;
	logic [15:0]  p_idle_cnt;
	phase_state_t p_phase;
	logic [8:0]   p_half;
	logic         p_level;
	logic         p_second;
	logic [7:0]   p_qcnt;
	logic [1:0]   p_qidx;
	byte_state_t  p_byte;
	logic [7:0]   p_shift;
	logic [2:0]   p_bits;

	pins_t       pending_ticks[$];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit          gaps_on;
	int unsigned squeeze_reqs;
	bit          out_took = 1'b0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void sequencer_reset();
		quarter_clocks = QUARTER_BIT_CLOCKS_RESET;
		idle_bit_count = IDLE_BITS_RESET;
		p_top = TOP_IDLE;
		p_id = '0;
		p_addr = '0;
		p_result = '0;
		p_seq = SEQ_WRITE;
		p_idle_cnt = '0;
		p_phase = PH_START;
		p_half = '0;
		p_level = 1'b0;
		p_second = 1'b0;
		p_qcnt = '0;
		p_qidx = '0;
		p_byte = BYTE_FIRST;
		p_shift = '0;
		p_bits = '0;
	endfunction

	// Quarter-bit timer of start and stop conditions; 1 when the fourth quarter ends.
	function automatic bit quarter_tick(input int unsigned qlen);
		if (p_qcnt == 8'(qlen - 1)) begin
			p_qcnt = '0;
			if (p_qidx == 2'd3) begin
				p_qidx = '0;
				return 1'b1;
			end
			p_qidx = p_qidx + 2'd1;
		end else begin
			p_qcnt = p_qcnt + 8'd1;
		end
		return 1'b0;
	endfunction

	function automatic bit send_byte(input logic [7:0] data, input bit change_now,
			output logic sda);
		sda = 1'b1;
		if (p_byte == BYTE_FIRST) begin
			p_shift = data;
			p_bits = '0;
			p_byte = BYTE_MID;
		end
		if (p_byte == BYTE_MID) begin
			sda = p_shift[7];
			if (change_now) begin
				p_shift = {p_shift[6:0], 1'b0};
				if (p_bits == 3'd7)
					p_byte = BYTE_ACK;
				else
					p_bits = p_bits + 3'd1;
			end
		end else if (p_byte == BYTE_ACK) begin
			// acknowledge slot is driven low by the master
			sda = 1'b0;
			if (change_now) begin
				p_byte = BYTE_FIRST;
				p_bits = '0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic bit receive_byte(input bit sample_now, input bit change_now,
			input logic din, output logic sda, output logic en);
		sda = 1'b0;
		en = 1'b0;
		if (p_byte == BYTE_FIRST) begin
			if (sample_now) begin
				p_shift = {p_shift[6:0], din};
				if (p_bits == 3'd7)
					p_byte = BYTE_MID;
				else
					p_bits = p_bits + 3'd1;
			end
		end else if (p_byte == BYTE_MID) begin
			if (change_now)
				p_byte = BYTE_ACK;
		end else if (p_byte == BYTE_ACK) begin
			// no-acknowledge: drive high
			sda = 1'b1;
			en = 1'b1;
			if (change_now) begin
				p_byte = BYTE_FIRST;
				p_bits = '0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void frame_tick(input int unsigned qlen, input logic din,
			output logic scl_o, output logic sda_o, output logic en_o);
		bit rd;
		bit mid;
		bit change_now;
		bit sample_now;
		logic [7:0] data;
		rd = (p_seq == SEQ_READ);
		mid = (p_half == 9'(qlen - 1));
		change_now = !p_level && mid;
		sample_now = p_level && mid;
		scl_o = p_level;
		sda_o = 1'b1;
		en_o = 1'b1;
		if (p_half == 9'(2 * qlen - 1)) begin
			p_half = '0;
			p_level = ~p_level;
		end else begin
			p_half = p_half + 9'd1;
		end
		if (p_phase == PH_START) begin
			scl_o = (p_qidx != 2'd3);
			sda_o = (p_qidx < 2'd2);
			if (quarter_tick(qlen)) begin
				// byte timing starts mid-low so data changes before the first rise
				p_half = qlen[8:0];
				p_level = 1'b0;
				p_second = 1'b0;
				p_phase = PH_WRITE;
			end
		end else if (p_phase == PH_WRITE) begin
			if (rd)
				data = p_id | 8'h01;
			else
				data = p_second ? p_addr : (p_id & 8'hFE);
			if (send_byte(data, change_now, sda_o)) begin
				if (rd)
					p_phase = PH_READ;
				else if (p_second)
					p_phase = PH_STOP;
				else
					p_second = 1'b1;
			end
		end else if (p_phase == PH_READ) begin
			if (rd && receive_byte(sample_now, change_now, din, sda_o, en_o))
				p_phase = PH_STOP;
		end else begin
			scl_o = (p_qidx != 2'd0);
			sda_o = (p_qidx >= 2'd2);
			if (quarter_tick(qlen)) begin
				p_phase = PH_START;
				p_seq = rd ? SEQ_READ_IDLE : SEQ_WRITE_IDLE;
				p_idle_cnt = '0;
			end
		end
	endfunction

	// One system clock tick of the sequencer; returns the pins seen on that tick.
	function automatic pins_t sequencer_tick(input tick_in_t t);
		pins_t r;
		int unsigned qlen;
		int unsigned target;
		bit idle_done;
		r = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, p_result};
		if (p_top == TOP_IDLE) begin
			r.request_ready = 1'b1;
			if (t.request_valid) begin
				p_id = t.dev_id;
				p_addr = t.reg_addr;
				p_top = TOP_RUN;
			end
		end else if (p_top == TOP_RUN) begin
			qlen = (quarter_clocks == 8'd0) ? 256 : 32'(quarter_clocks);
			// zero idle bits wraps the target to the full 16-bit count
			target = (32'(idle_bit_count) * 4 * qlen - 1) & 32'hFFFF;
			idle_done = (p_idle_cnt == target[15:0]);
			p_idle_cnt = p_idle_cnt + 16'd1;
			if (p_seq == SEQ_WRITE || p_seq == SEQ_READ) begin
				frame_tick(qlen, t.sda_in, r.scl, r.sda_out, r.sda_drive_enable);
			end else if (p_seq == SEQ_WRITE_IDLE) begin
				if (idle_done)
					p_seq = SEQ_READ;
			end else if (idle_done) begin
				p_result = p_shift;
				p_top = TOP_PRESENT;
				p_seq = SEQ_WRITE;
			end
		end else begin
			r.result_valid = 1'b1;
			if (t.result_taken)
				p_top = TOP_IDLE;
		end
		return r;
	endfunction

	function automatic tick_in_t random_tick();
		tick_in_t t;
		t.request_valid = ($urandom_range(0, 3) != 0);
		t.dev_id = 8'($urandom);
		t.reg_addr = 8'($urandom);
		t.result_taken = ($urandom_range(0, 3) == 0);
		t.sda_in = 1'($urandom);
		return t;
	endfunction

	function automatic void check_pin(input string pin, input logic [7:0] want,
			input logic [7:0] got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, pin, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_tick(input tick_in_t t, input logic typed, input pins_t want);
		int unsigned gap;
		pins_t predicted;
		gap = gaps_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		{request_valid, dev_id, reg_addr, result_taken, sda_in} = t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = sequencer_tick(t);
		pending_ticks.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic write_timing_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [7:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_QUARTER_BIT_CLOCKS: quarter_clocks = value;
			REG_IDLE_BITS: idle_bit_count = value[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Wait until every predicted tick has come out, then let the pipeline settle.
	task automatic drain();
		in_valid = 1'b0;
		while (pending_ticks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_phase(input logic [7:0] q, input logic [3:0] idle_b,
			input int unsigned n_items, input bit with_gaps, input int unsigned squeeze_at);
		drain();
		write_timing_reg(REG_QUARTER_BIT_CLOCKS, q);
		write_timing_reg(REG_IDLE_BITS, {4'b0000, idle_b});
		gaps_on = with_gaps;
		for (int unsigned i = 1; i <= n_items; i++) begin
			if (i == squeeze_at)
				squeeze_reqs++;
			send_tick(random_tick(), 1'b0, NO_PINS);
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[sccb_register_read_master] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin : tick_check
		pins_t want;
		out_took = arst_n && out_valid && !out_stall;
		if (out_took) begin
			if (pending_ticks.size() == 0) begin
				$display("%0t ns: unexpected output transaction, got %0b%0b%0b%0b%0b %0h",
					$time, scl, sda_out, sda_drive_enable, request_ready, result_valid,
					read_byte);
				mismatches++;
			end else begin
				want = pending_ticks.pop_front();
				check_pin("scl", 8'(want.scl), 8'(scl));
				check_pin("sda_out", 8'(want.sda_out), 8'(sda_out));
				check_pin("sda_drive_enable", 8'(want.sda_drive_enable),
					8'(sda_drive_enable));
				check_pin("request_ready", 8'(want.request_ready), 8'(request_ready));
				check_pin("result_valid", 8'(want.result_valid), 8'(result_valid));
				check_pin("read_byte", want.read_byte, read_byte);
			end
		end
	end

	// Consumer: random hold-off per transaction, plus one long stall on request.
	initial begin : consumer
		int unsigned rx_wait;
		int unsigned hold_left;
		int unsigned squeeze_seen;
		rx_wait = 0;
		hold_left = 0;
		squeeze_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze_reqs != squeeze_seen) begin
				squeeze_seen = squeeze_reqs;
				hold_left = 80;
			end
			if (out_took)
				rx_wait = gaps_on ? $urandom_range(0, 9) : 0;
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_stall = 1'b1;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	initial begin : stimulus
		directed_row_t plan [0:9];
		gaps_on = 1'b1;
		squeeze_reqs = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_QUARTER_BIT_CLOCKS;
		cfg_data = '0;
		in_valid = 1'b0;
		request_valid = 1'b0;
		dev_id = '0;
		reg_addr = '0;
		result_taken = 1'b0;
		sda_in = 1'b0;
		sequencer_reset();

		// Idle ticks after reset, a request taken with the bus still idle, then
		// the first quarter of the start condition; later rows are predicted.
		plan = '{
			'{'{1'b0, 8'hFF, 8'hFF, 1'b1, 1'b1}, 1'b1, BUS_IDLE},
			'{'{1'b0, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b1, BUS_IDLE},
			'{'{1'b0, 8'hAA, 8'h55, 1'b1, 1'b0}, 1'b1, BUS_IDLE},
			'{'{1'b1, 8'hFF, 8'h00, 1'b0, 1'b1}, 1'b1, BUS_IDLE},
			'{'{1'b1, 8'h00, 8'hFF, 1'b1, 1'b0}, 1'b1, BUS_START},
			'{'{1'b0, 8'h55, 8'hAA, 1'b0, 1'b1}, 1'b0, NO_PINS},
			'{'{1'b1, 8'h80, 8'h01, 1'b1, 1'b0}, 1'b0, NO_PINS},
			'{'{1'b0, 8'h01, 8'h80, 1'b0, 1'b1}, 1'b0, NO_PINS},
			'{'{1'b1, 8'hFE, 8'h7F, 1'b1, 1'b1}, 1'b0, NO_PINS},
			'{'{1'b0, 8'h7F, 8'hFE, 1'b0, 1'b0}, 1'b0, NO_PINS}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i])
			send_tick(plan[i].stim, plan[i].typed, plan[i].want);

		// shortest timing: the quarter counter wraps first, then a full read
		run_phase(8'd1, 4'd1, 450, 1'b1, 100);
		run_phase(8'd2, 4'd3, 80, 1'b1, 0);
		run_phase(8'd3, 4'd15, 40, 1'b0, 0);
		// zero quarter length acts as 256, zero idle bits wraps the target
		run_phase(8'd0, 4'd0, 40, 1'b0, 0);
		run_phase(8'd255, 4'd15, 30, 1'b1, 0);

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_ticks.size() == 0)
			$display("[sccb_register_read_master] OK");
		else
			$display("[sccb_register_read_master] ERROR");
		$finish;
	end

endmodule
